// File: rtl/mandelbrot_escape_time_macros.svh
// ----------------------------------------------------------------------------
// mandelbrot_escape_time assertion macros
// Concurrent assertion wrappers on clk and rst_n, compiled out by NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define MBE_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define MBE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MBE_ASSERT_IMPLY(label, ante, cons, msg)
`define MBE_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: rtl/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types, sizes and helpers of the Mandelbrot escape-time block.
// ----------------------------------------------------------------------------
package mbe_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 24;
  localparam int ITER_WIDTH  = 16;

  localparam logic [ITER_WIDTH-1:0] MAX_ITER_RESET = ITER_WIDTH'(1000);

  // working width of z: holds c plus a squared term below 100
  localparam int Z_WIDTH = ((COORD_WIDTH > FRAC_BITS + 8) ? COORD_WIDTH : FRAC_BITS + 8) + 1;
  // multiplier operand: |z| < 10 fits in FRAC_BITS+4 magnitude bits
  localparam int MUL_WIDTH  = FRAC_BITS + 5;
  localparam int PROD_WIDTH = 2 * MUL_WIDTH;

  localparam logic signed [Z_WIDTH-1:0] Z_EDGE     = Z_WIDTH'(10) << FRAC_BITS;
  localparam logic signed [Z_WIDTH-1:0] Z_NEG_EDGE = -Z_EDGE;
  localparam logic [PROD_WIDTH:0] ESC_LIMIT = (PROD_WIDTH+1)'(100) << (2 * FRAC_BITS);

  localparam logic signed [Z_WIDTH-1:0] SAT_MAX =
    (Z_WIDTH'(1) << (COORD_WIDTH - 1)) - Z_WIDTH'(1);
  localparam logic signed [Z_WIDTH-1:0] SAT_MIN = -SAT_MAX - Z_WIDTH'(1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] c_real;
    logic signed [COORD_WIDTH-1:0] c_imag;
  } in_data_t;

  typedef struct packed {
    logic        [ITER_WIDTH-1:0]  iteration_count;
    logic signed [COORD_WIDTH-1:0] final_real;
    logic signed [COORD_WIDTH-1:0] final_imag;
  } out_data_t;

  typedef enum logic [1:0] {
    KIND_ITERATE,
    KIND_NO_STEPS,
    KIND_ORIGIN
  } work_kind_t;

  typedef struct packed {
    work_kind_t              kind;
    in_data_t                point;
    logic [ITER_WIDTH-1:0]   max_iter;
  } work_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } core_state_t;

  function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
    input logic signed [Z_WIDTH-1:0] v
  );
    logic signed [Z_WIDTH-1:0] s;
    s = v;
    if (v > SAT_MAX) begin
      s = SAT_MAX;
    end else if (v < SAT_MIN) begin
      s = SAT_MIN;
    end
    return COORD_WIDTH'(s);
  endfunction

endpackage

// File: rtl/mbe_queue.sv
// ----------------------------------------------------------------------------
// mbe_queue
// Short register queue of classified work between front and iteration core.
// ----------------------------------------------------------------------------
module mbe_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mbe_pkg::work_t wdata,
  output logic           full,
  input  logic           pop,
  output mbe_pkg::work_t rdata,
  output logic           empty
);
  import mbe_pkg::*;

  work_t                 mem_r [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_WIDTH-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                  do_push, do_pop;

  assign full    = (cnt_r == QCNT_WIDTH'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: rtl/mbe_front.sv
// ----------------------------------------------------------------------------
// mbe_front
// Accepts points, tags them with the current limit and sorts out trivial cases.
// ----------------------------------------------------------------------------
module mbe_front (
  input  logic                                  in_push,
  output logic                                  in_full,
  input  mbe_pkg::in_data_t                     in_data,
  input  logic [mbe_pkg::ITER_WIDTH-1:0]        max_iter,
  input  logic                                  q_full,
  output logic                                  q_push,
  output mbe_pkg::work_t                        q_data
);
  import mbe_pkg::*;

  work_kind_t kind;

  // zero limit gives no step; c = 0 is a fixed point on the first step
  always_comb begin
    if (max_iter == '0) begin
      kind = KIND_NO_STEPS;
    end else if (in_data.c_real == '0 && in_data.c_imag == '0) begin
      kind = KIND_ORIGIN;
    end else begin
      kind = KIND_ITERATE;
    end
  end

  assign in_full         = q_full;
  assign q_push          = in_push && !q_full;
  assign q_data.kind     = kind;
  assign q_data.point    = in_data;
  assign q_data.max_iter = max_iter;

endmodule

// File: rtl/mbe_core.sv
// ----------------------------------------------------------------------------
// mbe_core
// Iteration engine: squares z in state ST_MUL, adds and tests in ST_ADD after it,
// and holds the finished result in an output register.
// ----------------------------------------------------------------------------
module mbe_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  mbe_pkg::work_t       q_data,
  output logic                 q_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output mbe_pkg::out_data_t   out_data
);
  import mbe_pkg::*;

  core_state_t                   state_r, state_nxt;
  logic signed [COORD_WIDTH-1:0] cr_r, cr_nxt, ci_r, ci_nxt;
  logic [ITER_WIDTH-1:0]         max_r, max_nxt, cnt_r, cnt_nxt;
  logic signed [Z_WIDTH-1:0]     zr_r, zr_nxt, zi_r, zi_nxt;
  logic signed [PROD_WIDTH-1:0]  xx_r, xx_nxt, yy_r, yy_nxt, xy_r, xy_nxt;
  logic                          out_valid_r, out_valid_nxt;
  out_data_t                     out_data_r, out_data_nxt;

  logic signed [MUL_WIDTH-1:0]   mr, mi;
  logic [PROD_WIDTH:0]           sum_sq;
  logic signed [PROD_WIDTH:0]    diff, diff_sh, two_xy, two_xy_sh;
  logic signed [Z_WIDTH-1:0]     nr, ni;
  logic                          cnt_done, off_edge, escaped, fixed_pt, out_free;

  // operands are exact whenever z passed the edge test
  assign mr = signed'(zr_r[MUL_WIDTH-1:0]);
  assign mi = signed'(zi_r[MUL_WIDTH-1:0]);

  assign sum_sq    = (PROD_WIDTH+1)'(unsigned'(xx_r)) + (PROD_WIDTH+1)'(unsigned'(yy_r));
  assign diff      = (PROD_WIDTH+1)'(xx_r) - (PROD_WIDTH+1)'(yy_r);
  assign diff_sh   = diff >>> FRAC_BITS;
  assign two_xy    = signed'({xy_r, 1'b0});
  assign two_xy_sh = two_xy >>> FRAC_BITS;
  assign nr        = signed'(Z_WIDTH'(diff_sh)) + signed'(Z_WIDTH'(cr_r));
  assign ni        = signed'(Z_WIDTH'(two_xy_sh)) + signed'(Z_WIDTH'(ci_r));

  assign cnt_done = (cnt_r == max_r);
  assign off_edge = (zr_r >= Z_EDGE) || (zr_r <= Z_NEG_EDGE) ||
                    (zi_r >= Z_EDGE) || (zi_r <= Z_NEG_EDGE);
  assign escaped  = (sum_sq >= ESC_LIMIT);
  assign fixed_pt = (nr == zr_r) && (ni == zi_r);
  assign out_free = !out_valid_r || out_pop;

  assign out_empty = !out_valid_r;
  assign out_data  = out_data_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = (q_data.kind == KIND_ITERATE) ? ST_MUL : ST_DONE;
        end
      end
      ST_MUL: begin
        state_nxt = (cnt_done || off_edge) ? ST_DONE : ST_ADD;
      end
      ST_ADD: begin
        state_nxt = (escaped || fixed_pt) ? ST_DONE : ST_MUL;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    q_pop         = 1'b0;
    cr_nxt        = cr_r;
    ci_nxt        = ci_r;
    max_nxt       = max_r;
    cnt_nxt       = cnt_r;
    zr_nxt        = zr_r;
    zi_nxt        = zi_r;
    xx_nxt        = xx_r;
    yy_nxt        = yy_r;
    xy_nxt        = xy_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_pop;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cr_nxt  = q_data.point.c_real;
          ci_nxt  = q_data.point.c_imag;
          max_nxt = q_data.max_iter;
          zr_nxt  = '0;
          zi_nxt  = '0;
          cnt_nxt = (q_data.kind == KIND_ORIGIN) ? q_data.max_iter : '0;
        end
      end
      ST_MUL: begin
        xx_nxt = mr * mr;
        yy_nxt = mi * mi;
        xy_nxt = mr * mi;
      end
      ST_ADD: begin
        if (!escaped) begin
          if (fixed_pt) begin
            cnt_nxt = max_r;
          end else begin
            zr_nxt  = nr;
            zi_nxt  = ni;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.iteration_count = cnt_r;
          out_data_nxt.final_real      = sat_coord(zr_r);
          out_data_nxt.final_imag      = sat_coord(zi_r);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cr_r       <= cr_nxt;
    ci_r       <= ci_nxt;
    max_r      <= max_nxt;
    cnt_r      <= cnt_nxt;
    zr_r       <= zr_nxt;
    zi_r       <= zi_nxt;
    xx_r       <= xx_nxt;
    yy_r       <= yy_nxt;
    xy_r       <= xy_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// File: rtl/mandelbrot_escape_time.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time iteration of one point c in signed Q8.24. Points enter through a
// push/full queue port and results leave through an empty/pop queue port, one
// result per point: the count of steps z = z*z + c done before |z|^2 reaches
// 100, the limit cfg_wdata sets (reset 1000) for points that never escape or
// hit a fixed point, and the last z saturated to Q8.24. The iteration core
// does each step in ST_MUL (three 29x29 products) and then in ST_ADD (add and
// test). It stops a point when it leaves the |z| < 10 box, when the |z|^2
// test stops it, on a fixed point or when it reaches the limit; points
// with c = 0 or a zero limit go from the queue straight to the result. A
// pushed point is registered in the queue before the core can take it, and
// the core holds a finished result while the output register is full.
// A two-entry queue ahead of the core takes new points while it works, and the
// output register holds a finished result while the core moves on to the next
// point.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_macros.svh"

module mandelbrot_escape_time (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  mbe_pkg::in_data_t               in_data,
  output logic                            out_empty,
  input  logic                            out_pop,
  output mbe_pkg::out_data_t              out_data,
  input  logic                            cfg_we,
  input  logic [mbe_pkg::ITER_WIDTH-1:0]  cfg_wdata
);
  import mbe_pkg::*;

  logic [ITER_WIDTH-1:0] max_iter_r, max_iter_nxt;
  logic                  q_push, q_full, q_pop, q_empty;
  work_t                 q_wdata, q_rdata;
  logic                  out_escaped, out_z_zero;

  assign max_iter_nxt = cfg_we ? cfg_wdata : max_iter_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= MAX_ITER_RESET;
    end else begin
      max_iter_r <= max_iter_nxt;
    end
  end

  mbe_front u_front (
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .max_iter (max_iter_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  mbe_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  mbe_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  // a count below the limit means the point escaped, so z cannot be zero
  assign out_escaped = !out_empty && (out_data.iteration_count != max_iter_r);
  assign out_z_zero  = (out_data.final_real == '0) && (out_data.final_imag == '0);

  `MBE_ASSERT_IMPLY(a_escape_nonzero, out_escaped, !out_z_zero, "escaped result with zero z")
  `MBE_ASSERT_IMPLY(a_pop_nonempty, q_pop, !q_empty, "core took work from an empty queue")
  `MBE_ASSERT_NEXT(a_request_queued, in_push && !in_full, !q_empty, "accepted request not queued")

endmodule
